// File: src/csru_pkg.sv
// Shared types, widths, codes and helpers for the cardinality sketch register update block.
// No dependencies; every other file uses this package by scoped names.
`default_nettype none
package csru_pkg;

    // Field widths of the input and result beats.
    localparam int ACTION_W = 2;
    localparam int HASH_W   = 64;
    localparam int RIDX_W   = 14;
    localparam int RVAL_W   = 6;
    localparam int OCC_W    = 13;
    localparam int ZERO_W   = 15;
    localparam int HSUM_W   = 63;
    localparam int KEY_W    = 63;
    localparam int RANK_W   = 6;
    localparam int SHAMT_W  = 6;

    // Configuration register widths and reset values.
    localparam int PREC_W  = 4;
    localparam int FINE_W  = 6;
    localparam int LIMIT_W = 12;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [PREC_W-1:0]  PREC_RST  = 4'd14;
    localparam logic [FINE_W-1:0]  FINE_RST  = 6'd25;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 12'd3072;
    localparam logic               START_RST = 1'b1;

    // Register indexes (byte address 4*i).
    localparam logic [1:0] REG_PRECISION = 2'd0;
    localparam logic [1:0] REG_FINE      = 2'd1;
    localparam logic [1:0] REG_LIMIT     = 2'd2;
    localparam logic [1:0] REG_START     = 2'd3;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MERGE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    // Datapath commands.
    typedef logic [4:0] op_t;
    localparam op_t OP_NOP        = 5'd0;
    localparam op_t OP_CLR_START  = 5'd1;
    localparam op_t OP_CLR        = 5'd2;
    localparam op_t OP_CAPTURE    = 5'd3;
    localparam op_t OP_PREP_INS   = 5'd4;
    localparam op_t OP_RANK       = 5'd5;
    localparam op_t OP_SP_RD      = 5'd6;
    localparam op_t OP_SP_UPD     = 5'd7;
    localparam op_t OP_PTR_INC    = 5'd8;
    localparam op_t OP_APPEND     = 5'd9;
    localparam op_t OP_PTR_CLR    = 5'd10;
    localparam op_t OP_PR_PREP    = 5'd11;
    localparam op_t OP_PR_END     = 5'd12;
    localparam op_t OP_LOAD_MERGE = 5'd13;
    localparam op_t OP_DN_RD      = 5'd14;
    localparam op_t OP_DN_WR      = 5'd15;
    localparam op_t OP_RESULT     = 5'd16;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                sparse;
        logic                key_match;
        logic                scan_last;
        logic                used_zero;
        logic                over_limit;
        logic                in_range;
        logic                clr_last;
    } status_t;

    typedef struct packed {
        logic [PREC_W-1:0]  precision;
        logic [FINE_W-1:0]  fine;
        logic [LIMIT_W-1:0] limit;
        logic               start_sparse;
    } cfg_t;

    // Position of the highest set bit plus one; zero for a zero word.
    function automatic logic [6:0] bit_len(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// File: src/csru_ctrl.sv
// Sequencer for the sketch: walks each action through the datapath one command per cycle.
// Depends on csru_pkg (cmd_t, status_t, op and action codes).
`default_nettype none
module csru_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire csru_pkg::status_t status_i,
    output csru_pkg::cmd_t         cmd_o
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DISPATCH  = 5'd1;
    localparam logic [4:0] S_RANK      = 5'd2;
    localparam logic [4:0] S_MERGE     = 5'd3;
    localparam logic [4:0] S_DN_RD     = 5'd4;
    localparam logic [4:0] S_DN_WR     = 5'd5;
    localparam logic [4:0] S_PR_START  = 5'd6;
    localparam logic [4:0] S_PR_RD     = 5'd7;
    localparam logic [4:0] S_PR_PREP   = 5'd8;
    localparam logic [4:0] S_PR_END    = 5'd9;
    localparam logic [4:0] S_SP_RD     = 5'd10;
    localparam logic [4:0] S_SP_CMP    = 5'd11;
    localparam logic [4:0] S_SP_APPEND = 5'd12;
    localparam logic [4:0] S_LIMIT     = 5'd13;
    localparam logic [4:0] S_CLR_START = 5'd14;
    localparam logic [4:0] S_CLEAR     = 5'd15;
    localparam logic [4:0] S_DONE      = 5'd16;

    logic [4:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       prom_reg, prom_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && !cfg_wr;
    assign m_valid  = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        prom_next   = prom_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd_o.op    = csru_pkg::OP_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd_o.op   = csru_pkg::OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (status_i.action)
                    csru_pkg::ACT_INSERT: begin
                        cmd_o.op   = csru_pkg::OP_PREP_INS;
                        prom_next  = 1'b0;
                        state_next = S_RANK;
                    end
                    csru_pkg::ACT_MERGE: begin
                        state_next = status_i.sparse ? S_PR_START : S_MERGE;
                    end
                    csru_pkg::ACT_QUERY: begin
                        state_next = S_DONE;
                    end
                    default: begin
                        pend_next  = 1'b1;
                        state_next = S_CLR_START;
                    end
                endcase
            end
            S_RANK: begin
                cmd_o.op = csru_pkg::OP_RANK;
                if (prom_reg || !status_i.sparse) begin
                    state_next = S_DN_RD;
                end else begin
                    state_next = status_i.used_zero ? S_SP_APPEND : S_SP_RD;
                end
            end
            S_MERGE: begin
                if (status_i.in_range) begin
                    cmd_o.op   = csru_pkg::OP_LOAD_MERGE;
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DN_RD: begin
                cmd_o.op   = csru_pkg::OP_DN_RD;
                state_next = S_DN_WR;
            end
            S_DN_WR: begin
                cmd_o.op = csru_pkg::OP_DN_WR;
                if (prom_reg) begin
                    state_next = status_i.scan_last ? S_PR_END : S_PR_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PR_START: begin
                cmd_o.op   = csru_pkg::OP_PTR_CLR;
                prom_next  = 1'b1;
                state_next = status_i.used_zero ? S_PR_END : S_PR_RD;
            end
            S_PR_RD: begin
                cmd_o.op   = csru_pkg::OP_SP_RD;
                state_next = S_PR_PREP;
            end
            S_PR_PREP: begin
                cmd_o.op   = csru_pkg::OP_PR_PREP;
                state_next = S_RANK;
            end
            S_PR_END: begin
                cmd_o.op   = csru_pkg::OP_PR_END;
                prom_next  = 1'b0;
                state_next = (status_i.action == csru_pkg::ACT_MERGE) ? S_MERGE : S_DONE;
            end
            S_SP_RD: begin
                cmd_o.op   = csru_pkg::OP_SP_RD;
                state_next = S_SP_CMP;
            end
            S_SP_CMP: begin
                if (status_i.key_match) begin
                    cmd_o.op   = csru_pkg::OP_SP_UPD;
                    state_next = S_DONE;
                end else if (status_i.scan_last) begin
                    state_next = S_SP_APPEND;
                end else begin
                    cmd_o.op   = csru_pkg::OP_PTR_INC;
                    state_next = S_SP_RD;
                end
            end
            S_SP_APPEND: begin
                cmd_o.op   = csru_pkg::OP_APPEND;
                state_next = S_LIMIT;
            end
            S_LIMIT: begin
                state_next = status_i.over_limit ? S_PR_START : S_DONE;
            end
            S_CLR_START: begin
                cmd_o.op   = csru_pkg::OP_CLR_START;
                state_next = S_CLEAR;
            end
            S_CLEAR: begin
                cmd_o.op = csru_pkg::OP_CLR;
                if (status_i.clr_last) begin
                    state_next = pend_reg ? S_DONE : S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd_o.op    = csru_pkg::OP_RESULT;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR_START;
            end
        endcase
        // A register write reinitializes the sketch: restart the sweep.
        if (cfg_wr) begin
            cmd_o.op   = csru_pkg::OP_NOP;
            pend_next  = 1'b0;
            prom_next  = 1'b0;
            state_next = S_CLR_START;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLR_START;
            pend_reg   <= 1'b0;
            prom_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            prom_reg   <= prom_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule
`default_nettype wire

// File: src/csru_dp.sv
// Datapath of the sketch: dense rank memory, sparse key/rank table, tallies and result register.
// Depends on csru_pkg (cmd_t, status_t, cfg_t, op codes, bit_len).
`default_nettype none
module csru_dp #(
    parameter int MAX_PRECISION = 14,
    parameter int SPARSE_CAP    = 4096,
    parameter int FRAC_BITS     = 48
) (
    input  wire logic                               aclk,
    input  wire csru_pkg::cfg_t                     cfg_i,
    input  wire csru_pkg::cmd_t                     cmd_i,
    output csru_pkg::status_t                       status_o,
    input  wire logic [csru_pkg::ACTION_W-1:0]      s_action,
    input  wire logic [csru_pkg::HASH_W-1:0]        s_hash_value,
    input  wire logic [csru_pkg::RIDX_W-1:0]        s_reg_index,
    input  wire logic [csru_pkg::RVAL_W-1:0]        s_reg_value,
    output logic                                    m_sparse_now,
    output logic [csru_pkg::OCC_W-1:0]              m_occupied_entries,
    output logic [csru_pkg::ZERO_W-1:0]             m_zero_registers,
    output logic [csru_pkg::HSUM_W-1:0]             m_harmonic_sum
);

    localparam int DEPTH = 1 << MAX_PRECISION;
    localparam int MP    = MAX_PRECISION;
    localparam int UW    = $clog2(SPARSE_CAP + 1);
    localparam int PW    = $clog2(SPARSE_CAP);
    localparam int LXW   = (UW > csru_pkg::LIMIT_W) ? UW : csru_pkg::LIMIT_W;
    localparam int ZW    = MAX_PRECISION + 1;
    localparam int KW    = csru_pkg::KEY_W;
    localparam int RW    = csru_pkg::RANK_W;
    localparam int SW    = csru_pkg::SHAMT_W;
    localparam int HW    = csru_pkg::HSUM_W;
    localparam logic [6:0]     FRAC7   = 7'(FRAC_BITS);
    localparam logic [SW-1:0]  MP6     = SW'(MAX_PRECISION);
    localparam logic [LXW-1:0] CAP_LIM = LXW'(SPARSE_CAP - 1);

    // Storage.
    logic [RW-1:0] dense_mem [DEPTH];
    logic [KW-1:0] key_mem   [SPARSE_CAP];
    logic [RW-1:0] srank_mem [SPARSE_CAP];

    logic [csru_pkg::ACTION_W-1:0] act_reg;
    logic [csru_pkg::HASH_W-1:0]   hash_reg;
    logic [csru_pkg::RIDX_W-1:0]   ridx_reg;
    logic [csru_pkg::RVAL_W-1:0]   rval_reg;
    logic [KW-1:0]                 key_reg;
    logic [63:0]                   src_reg;
    logic [SW-1:0]                 base_reg;
    logic [RW-1:0]                 zadd_reg;
    logic [RW-1:0]                 rank_reg;
    logic [MP-1:0]                 didx_reg;
    logic [UW-1:0]                 ptr_reg;
    logic [UW-1:0]                 used_reg;
    logic [MP-1:0]                 clr_reg;
    logic                          sparse_reg;
    logic [ZW-1:0]                 zero_reg;
    logic [HW-1:0]                 harm_reg;
    logic [KW-1:0]                 key_rd_reg;
    logic [RW-1:0]                 srank_rd_reg;
    logic [RW-1:0]                 drank_rd_reg;

    logic                          out_sparse_reg;
    logic [csru_pkg::OCC_W-1:0]    out_occ_reg;
    logic [csru_pkg::ZERO_W-1:0]   out_zero_reg;
    logic [HW-1:0]                 out_harm_reg;

    // Effective configuration.
    logic [SW-1:0]     prec6, b_eff, fine_eff, extra, sb_fine, sb_b, sb_sel;
    logic [MP:0]       one_b;
    logic [MP-1:0]     bmask;
    logic [LXW-1:0]    lim0, limit_eff;
    logic [HW-1:0]     harm_init;
    logic [6:0]        blen, r7;
    logic              raise;
    logic [MP+csru_pkg::RIDX_W-1:0] ridx_ext;
    logic [UW+csru_pkg::OCC_W-1:0]  occ_ext;
    logic [ZW+csru_pkg::ZERO_W-1:0] zero_ext;

    function automatic logic [HW-1:0] term(input logic [RW-1:0] r);
        logic [6:0] r7l;
        r7l = 7'(r);
        return (r7l <= FRAC7) ? (HW'(1) << (FRAC7 - r7l)) : '0;
    endfunction

    function automatic logic [63:0] mask64(input logic [SW-1:0] n);
        return (64'd1 << n) - 64'd1;
    endfunction

    always_comb begin
        prec6 = SW'(cfg_i.precision);
        if (prec6 < 6'd4) begin
            b_eff = 6'd4;
        end else if (prec6 > MP6) begin
            b_eff = MP6;
        end else begin
            b_eff = prec6;
        end
        fine_eff  = (cfg_i.fine < b_eff) ? b_eff : cfg_i.fine;
        extra     = fine_eff - b_eff;
        sb_fine   = SW'(7'd64 - 7'(fine_eff));
        sb_b      = SW'(7'd64 - 7'(b_eff));
        sb_sel    = sparse_reg ? sb_fine : sb_b;
        one_b     = (MP+1)'(1) << b_eff;
        bmask     = MP'(one_b - (MP+1)'(1));
        lim0      = (cfg_i.limit == '0) ? LXW'(1) : LXW'(cfg_i.limit);
        limit_eff = (lim0 > CAP_LIM) ? CAP_LIM : lim0;
        harm_init = HW'(1) << (7'(b_eff) + FRAC7);
        blen      = csru_pkg::bit_len(src_reg);
        r7        = (src_reg == 64'd0) ? (7'(base_reg) + 7'(zadd_reg))
                                       : (7'(base_reg) - blen + 7'd1);
        raise     = rank_reg > drank_rd_reg;
        ridx_ext  = (MP+csru_pkg::RIDX_W)'(ridx_reg);
        occ_ext   = sparse_reg ? (UW+csru_pkg::OCC_W)'(used_reg) : '0;
        zero_ext  = (ZW+csru_pkg::ZERO_W)'(zero_reg);
    end

    assign status_o.action     = act_reg;
    assign status_o.sparse     = sparse_reg;
    assign status_o.key_match  = key_rd_reg == key_reg;
    assign status_o.scan_last  = ({1'b0, ptr_reg} + (UW+1)'(1)) == {1'b0, used_reg};
    assign status_o.used_zero  = used_reg == '0;
    assign status_o.over_limit = LXW'(used_reg) > limit_eff;
    assign status_o.in_range   = (ridx_reg >> b_eff) == '0;
    assign status_o.clr_last   = clr_reg == bmask;

    // Dense rank memory: one port, read data registered.
    always_ff @(posedge aclk) begin
        if (cmd_i.op == csru_pkg::OP_CLR) begin
            dense_mem[clr_reg] <= '0;
        end else if (cmd_i.op == csru_pkg::OP_DN_WR && raise) begin
            dense_mem[didx_reg] <= rank_reg;
        end
        if (cmd_i.op == csru_pkg::OP_DN_RD) begin
            drank_rd_reg <= dense_mem[didx_reg];
        end
    end

    // Sparse key/rank table.
    always_ff @(posedge aclk) begin
        if (cmd_i.op == csru_pkg::OP_SP_UPD && rank_reg > srank_rd_reg) begin
            srank_mem[ptr_reg[PW-1:0]] <= rank_reg;
        end else if (cmd_i.op == csru_pkg::OP_APPEND) begin
            srank_mem[used_reg[PW-1:0]] <= rank_reg;
        end
        if (cmd_i.op == csru_pkg::OP_APPEND) begin
            key_mem[used_reg[PW-1:0]] <= key_reg;
        end
        if (cmd_i.op == csru_pkg::OP_SP_RD) begin
            key_rd_reg   <= key_mem[ptr_reg[PW-1:0]];
            srank_rd_reg <= srank_mem[ptr_reg[PW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd_i.op)
            csru_pkg::OP_CLR_START: begin
                clr_reg    <= '0;
                used_reg   <= '0;
                sparse_reg <= cfg_i.start_sparse;
                zero_reg   <= one_b;
                harm_reg   <= harm_init;
            end
            csru_pkg::OP_CLR: begin
                clr_reg <= clr_reg + MP'(1);
            end
            csru_pkg::OP_CAPTURE: begin
                act_reg  <= s_action;
                hash_reg <= s_hash_value;
                ridx_reg <= s_reg_index;
                rval_reg <= s_reg_value;
            end
            csru_pkg::OP_PREP_INS: begin
                src_reg  <= hash_reg & mask64(sb_sel);
                base_reg <= sb_sel;
                zadd_reg <= RW'(1);
                key_reg  <= KW'(hash_reg >> sb_fine);
                didx_reg <= MP'(hash_reg >> sb_b);
                ptr_reg  <= '0;
            end
            csru_pkg::OP_RANK: begin
                rank_reg <= r7[RW-1:0];
            end
            csru_pkg::OP_PTR_INC: begin
                ptr_reg <= ptr_reg + UW'(1);
            end
            csru_pkg::OP_APPEND: begin
                used_reg <= used_reg + UW'(1);
            end
            csru_pkg::OP_PTR_CLR: begin
                ptr_reg <= '0;
            end
            csru_pkg::OP_PR_PREP: begin
                src_reg  <= {1'b0, key_rd_reg} & mask64(extra);
                base_reg <= extra;
                zadd_reg <= srank_rd_reg;
                didx_reg <= MP'(key_rd_reg >> extra) & bmask;
            end
            csru_pkg::OP_PR_END: begin
                used_reg   <= '0;
                sparse_reg <= 1'b0;
            end
            csru_pkg::OP_LOAD_MERGE: begin
                didx_reg <= ridx_ext[MP-1:0];
                rank_reg <= rval_reg;
            end
            csru_pkg::OP_DN_WR: begin
                ptr_reg <= ptr_reg + UW'(1);
                if (raise) begin
                    if (drank_rd_reg == '0) begin
                        zero_reg <= zero_reg - ZW'(1);
                    end
                    harm_reg <= harm_reg - term(drank_rd_reg) + term(rank_reg);
                end
            end
            csru_pkg::OP_RESULT: begin
                out_sparse_reg <= sparse_reg;
                out_occ_reg    <= occ_ext[csru_pkg::OCC_W-1:0];
                out_zero_reg   <= zero_ext[csru_pkg::ZERO_W-1:0];
                out_harm_reg   <= harm_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_sparse_now       = out_sparse_reg;
    assign m_occupied_entries = out_occ_reg;
    assign m_zero_registers   = out_zero_reg;
    assign m_harmonic_sum     = out_harm_reg;

endmodule
`default_nettype wire

// File: src/cardinality_sketch_register_update.sv
// Top level of the cardinality sketch register update block: register port and the two parts.
// Depends on csru_pkg, csru_ctrl and csru_dp.
//
// Usage: each input beat (s_*) carries an action: insert a 64-bit hash, merge one dense
// register of another sketch, query, or clear. Every action returns exactly one result
// beat (m_*) with mode, sparse occupancy, zero-register count and harmonic sum, taken
// after the action. One action is worked at a time; the next input beat is taken while
// the previous result still waits on m_ready, and a result stays in its output register
// until taken (a stalled receiver holds the block once its next action is finished).
// s_ready returns in the same cycle as the result is raised. Sparse insert scans the key
// table entry by entry (memory read, compare). Promotion to dense works through each
// stored entry in turn (table read, remap, rank, dense read-modify-write). Clear, reset
// and any register write start a sweep that zeroes the 2^b dense registers (b: precision
// clamped to 4..MAX_PRECISION), one per cycle; s_ready is low during the sweep, and a
// clear action delivers its result after the sweep.
// Registers: 0 precision, 1 fine_precision, 2 sparse_limit, 3 start_sparse at 4*i.
`default_nettype none
module cardinality_sketch_register_update #(
    parameter int MAX_PRECISION = 14,
    parameter int SPARSE_CAP    = 4096,
    parameter int FRAC_BITS     = 48
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [csru_pkg::APB_AW-1:0]    paddr,
    input  wire logic [csru_pkg::APB_DW-1:0]    pwdata,
    output logic [csru_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [csru_pkg::ACTION_W-1:0]  s_action,
    input  wire logic [csru_pkg::HASH_W-1:0]    s_hash_value,
    input  wire logic [csru_pkg::RIDX_W-1:0]    s_reg_index,
    input  wire logic [csru_pkg::RVAL_W-1:0]    s_reg_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_sparse_now,
    output logic [csru_pkg::OCC_W-1:0]          m_occupied_entries,
    output logic [csru_pkg::ZERO_W-1:0]         m_zero_registers,
    output logic [csru_pkg::HSUM_W-1:0]         m_harmonic_sum
);

    csru_pkg::cfg_t    cfg_reg;
    csru_pkg::cmd_t    cmd;
    csru_pkg::status_t status;
    logic              cfg_wr;

    // The port never stalls; a write lands on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.precision    <= csru_pkg::PREC_RST;
            cfg_reg.fine         <= csru_pkg::FINE_RST;
            cfg_reg.limit        <= csru_pkg::LIMIT_RST;
            cfg_reg.start_sparse <= csru_pkg::START_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                csru_pkg::REG_PRECISION: cfg_reg.precision <= pwdata[csru_pkg::PREC_W-1:0];
                csru_pkg::REG_FINE:      cfg_reg.fine      <= pwdata[csru_pkg::FINE_W-1:0];
                csru_pkg::REG_LIMIT:     cfg_reg.limit     <= pwdata[csru_pkg::LIMIT_W-1:0];
                csru_pkg::REG_START:     cfg_reg.start_sparse <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        unique case (paddr[3:2])
            csru_pkg::REG_PRECISION: prdata = csru_pkg::APB_DW'(cfg_reg.precision);
            csru_pkg::REG_FINE:      prdata = csru_pkg::APB_DW'(cfg_reg.fine);
            csru_pkg::REG_LIMIT:     prdata = csru_pkg::APB_DW'(cfg_reg.limit);
            csru_pkg::REG_START:     prdata = csru_pkg::APB_DW'(cfg_reg.start_sparse);
            default:                 prdata = '0;
        endcase
    end

    // Sequencer: one datapath command per cycle.
    csru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status_i (status),
        .cmd_o    (cmd)
    );

    // Datapath: memories, tallies and the result register.
    csru_dp #(
        .MAX_PRECISION (MAX_PRECISION),
        .SPARSE_CAP    (SPARSE_CAP),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dp (
        .aclk               (aclk),
        .cfg_i              (cfg_reg),
        .cmd_i              (cmd),
        .status_o           (status),
        .s_action           (s_action),
        .s_hash_value       (s_hash_value),
        .s_reg_index        (s_reg_index),
        .s_reg_value        (s_reg_value),
        .m_sparse_now       (m_sparse_now),
        .m_occupied_entries (m_occupied_entries),
        .m_zero_registers   (m_zero_registers),
        .m_harmonic_sum     (m_harmonic_sum)
    );

`ifndef ASSERT_OFF
    // A register write starts the clearing sweep: no beat is taken right after it.
    a_cfg_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input taken right after a register write");

    // A dense sketch has no sparse entries.
    a_dense_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sparse_now |-> m_occupied_entries == '0)
        else $error("dense result reports sparse occupancy");

    // A result appears only out of the finishing step, never while input is open.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised while the block was idle");
`endif

endmodule
`default_nettype wire

// File: test/testbench.sv
// Testbench for cardinality_sketch_register_update: random and directed actions, self-checking.
// Depends on csru_pkg and the RTL of the block; holds its own sketch predictor class.
`default_nettype none

typedef struct packed {
    bit        sparse_now;
    bit [12:0] occupied;
    bit [14:0] zeros;
    bit [62:0] hsum;
} sketch_status_t;

class sketch_scoreboard;
    bit [3:0]  precision;
    bit [5:0]  fine;
    bit [11:0] limit;
    bit        start_sparse;

    bit [5:0]  reg_rank[16384];
    bit [62:0] fine_key[4096];
    bit [5:0]  fine_rank[4096];
    int        used;
    bit        sparse;
    int        zeros_left;
    bit [63:0] harmonic;

    sketch_status_t status_q[$];
    int errors;
    int mismatches;

    function new();
        precision    = csru_pkg::PREC_RST;
        fine         = csru_pkg::FINE_RST;
        limit        = csru_pkg::LIMIT_RST;
        start_sparse = csru_pkg::START_RST;
        errors       = 0;
        mismatches   = 0;
        wipe();
    endfunction

    function int index_bits();
        if (precision < 4) return 4;
        if (precision > 14) return 14;
        return int'(precision);
    endfunction

    function int fine_bits();
        return (int'(fine) < index_bits()) ? index_bits() : int'(fine);
    endfunction

    function int promote_limit();
        int l;
        l = (limit == 0) ? 1 : int'(limit);
        return (l > 4095) ? 4095 : l;
    endfunction

    function int msb_pos(bit [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = i + 1;
        end
        return n;
    endfunction

    function bit [63:0] term(int r);
        return (r <= 48) ? (64'd1 << (48 - r)) : 64'd0;
    endfunction

    function int rank(bit [63:0] h, int sb);
        bit [63:0] suffix;
        suffix = h & ((64'd1 << sb) - 1);
        if (suffix == 0) return sb + 1;
        return sb - msb_pos(suffix) + 1;
    endfunction

    function void raise(int idx, int r);
        int old;
        idx = idx & 16383;
        r   = r & 63;
        old = int'(reg_rank[idx]);
        if (r <= old) return;
        if (old == 0) zeros_left--;
        harmonic = harmonic - term(old) + term(r);
        reg_rank[idx] = 6'(r);
    endfunction

    function void wipe();
        foreach (reg_rank[i]) reg_rank[i] = 0;
        used       = 0;
        sparse     = start_sparse;
        zeros_left = 1 << index_bits();
        harmonic   = 64'd1 << (index_bits() + 48);
    endfunction

    function void promote();
        int        b;
        int        extra;
        int        r;
        bit [63:0] low;
        if (!sparse) return;
        b     = index_bits();
        extra = fine_bits() - b;
        for (int i = 0; i < used; i++) begin
            r = int'(fine_rank[i]);
            if (extra != 0) begin
                low = fine_key[i] & ((64'd1 << extra) - 1);
                r   = (low == 0) ? extra + r : extra - msb_pos(low) + 1;
            end
            raise(int'(fine_key[i] >> extra) & ((1 << b) - 1), r);
        end
        used   = 0;
        sparse = 0;
    endfunction

    function void add_hash(bit [63:0] h);
        int        sb;
        int        r;
        int        hit;
        bit [62:0] key;
        if (sparse) begin
            sb  = 64 - fine_bits();
            key = 63'(h >> sb);
            r   = rank(h, sb);
            hit = -1;
            for (int i = 0; i < used; i++) begin
                if (hit < 0 && fine_key[i] == key) hit = i;
            end
            if (hit >= 0) begin
                if (r > int'(fine_rank[hit])) fine_rank[hit] = 6'(r);
            end else if (used < 4096) begin
                fine_key[used]  = key;
                fine_rank[used] = 6'(r);
                used++;
            end
            if (used > promote_limit()) promote();
        end else begin
            sb = 64 - index_bits();
            raise(int'(h >> sb), rank(h, sb));
        end
    endfunction

    function void configure(bit [1:0] idx, bit [31:0] value);
        case (idx)
            csru_pkg::REG_PRECISION: precision = value[3:0];
            csru_pkg::REG_FINE:      fine = value[5:0];
            csru_pkg::REG_LIMIT:     limit = value[11:0];
            default:                 start_sparse = value[0];
        endcase
        wipe();
    endfunction

    // Work one accepted input beat and queue the status it must produce.
    function void note_input(bit [1:0] action, bit [63:0] h, bit [13:0] ridx, bit [5:0] rval);
        sketch_status_t s;
        case (action)
            csru_pkg::ACT_INSERT: add_hash(h);
            csru_pkg::ACT_MERGE: begin
                promote();
                if (int'(ridx) < (1 << index_bits())) raise(int'(ridx), int'(rval));
            end
            csru_pkg::ACT_CLEAR: wipe();
            default: ;
        endcase
        s.sparse_now = sparse;
        s.occupied   = sparse ? 13'(used) : 13'd0;
        s.zeros      = 15'(zeros_left);
        s.hsum       = harmonic[62:0];
        status_q.push_back(s);
    endfunction

    function void check(sketch_status_t got);
        sketch_status_t exp;
        if (status_q.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
            return;
        end
        exp = status_q.pop_front();
        if (got != exp) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch at %0t: exp sp=%0d occ=%0d zero=%0d hsum=%h",
                          " got sp=%0d occ=%0d zero=%0d hsum=%h"},
                         $time, exp.sparse_now, exp.occupied, exp.zeros, exp.hsum,
                         got.sparse_now, got.occupied, got.zeros, got.hsum);
        end
    endfunction
endclass

module testbench;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [csru_pkg::APB_AW-1:0] paddr = '0;
    logic [csru_pkg::APB_DW-1:0] pwdata = '0;
    logic [csru_pkg::APB_DW-1:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [csru_pkg::ACTION_W-1:0] s_action = '0;
    logic [csru_pkg::HASH_W-1:0]   s_hash_value = '0;
    logic [csru_pkg::RIDX_W-1:0]   s_reg_index = '0;
    logic [csru_pkg::RVAL_W-1:0]   s_reg_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_sparse_now;
    logic [csru_pkg::OCC_W-1:0]    m_occupied_entries;
    logic [csru_pkg::ZERO_W-1:0]   m_zero_registers;
    logic [csru_pkg::HSUM_W-1:0]   m_harmonic_sum;

    sketch_scoreboard sketch = new();
    bit        calm = 1'b0;   // no idling on either side in the closing phase
    bit [63:0] recent_hash[$];

    cardinality_sketch_register_update i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: alternate ready stretches with random stall bursts; stay ready when calm.
    initial begin
        forever begin
            if (calm || $urandom_range(0, 3) != 0) begin
                m_ready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end else begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
        end
    end

    // Check every result beat taken at the rising edge.
    always @(posedge aclk) begin
        sketch_status_t got;
        if (aresetn && m_valid && m_ready) begin
            got.sparse_now = m_sparse_now;
            got.occupied   = m_occupied_entries;
            got.zeros      = m_zero_registers;
            got.hsum       = m_harmonic_sum;
            sketch.check(got);
        end
    end

    // Hold the caller until the block has delivered every expected beat, then let it settle.
    task automatic drain();
        while (sketch.status_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // APB write: setup cycle then access cycle; the register takes it at the access edge.
    task automatic write_reg(bit [1:0] idx, bit [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = csru_pkg::APB_AW'(idx) << 2;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sketch.configure(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Present one beat and hold it until accepted; returns at a falling edge.
    task automatic send(bit [1:0] action, bit [63:0] h, bit [13:0] ridx, bit [5:0] rval);
        s_valid      = 1'b1;
        s_action     = action;
        s_hash_value = h;
        s_reg_index  = ridx;
        s_reg_value  = rval;
        do @(posedge aclk); while (!s_ready);
        sketch.note_input(action, h, ridx, rval);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
    endtask

    task automatic random_beat();
        int        pick;
        bit [63:0] h;
        bit [13:0] ridx;
        pick = $urandom_range(0, 99);
        h    = {$urandom, $urandom};
        if (recent_hash.size() != 0 && $urandom_range(0, 3) == 0) begin
            // reuse a known key so sparse hits and rank raises happen
            h = recent_hash[$urandom_range(0, recent_hash.size() - 1)];
            h[15:0] = 16'($urandom);
        end
        if ($urandom_range(0, 2) == 0) h &= ~((64'd1 << $urandom_range(0, 63)) - 1);
        recent_hash.push_back(h);
        if (recent_hash.size() > 16) void'(recent_hash.pop_front());
        ridx = 14'($urandom);
        if ($urandom_range(0, 1) == 0) begin
            ridx = 14'($urandom_range(0, (1 << sketch.index_bits()) - 1));
        end
        if (pick < 65)      send(csru_pkg::ACT_INSERT, h, ridx, 6'($urandom));
        else if (pick < 80) send(csru_pkg::ACT_MERGE, h, ridx, 6'($urandom));
        else if (pick < 97) send(csru_pkg::ACT_QUERY, h, ridx, 6'($urandom));
        else                send(csru_pkg::ACT_CLEAR, h, ridx, 6'($urandom));
    endtask

    // Settings per phase: precision, fine precision, sparse limit, start mode.
    int phase_cfg[8][4] = '{
        '{4, 4, 1, 1},  '{4, 63, 4095, 1}, '{15, 0, 0, 0}, '{0, 3, 8, 1},
        '{8, 20, 50, 1}, '{6, 12, 200, 1}, '{14, 40, 30, 1}, '{10, 10, 16, 1}
    };

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: sparse start at reset settings, extremes and every action.
        send(csru_pkg::ACT_QUERY,  64'd0, 14'd0, 6'd0);
        send(csru_pkg::ACT_INSERT, 64'd0, 14'd0, 6'd0);
        send(csru_pkg::ACT_INSERT, '1, 14'd0, 6'd0);
        send(csru_pkg::ACT_INSERT, 64'hFFFF_FF80_0000_0000, 14'd0, 6'd0);
        send(csru_pkg::ACT_INSERT, 64'hFFFF_FF80_0000_0001, 14'd0, 6'd0);
        send(csru_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 14'd0, 6'd0);
        send(csru_pkg::ACT_MERGE,  64'd0, 14'd0, 6'd63);
        send(csru_pkg::ACT_MERGE,  64'd0, 14'd16383, 6'd0);
        send(csru_pkg::ACT_MERGE,  64'd0, 14'd16383, 6'd48);
        send(csru_pkg::ACT_MERGE,  64'd0, 14'd5, 6'd49);
        send(csru_pkg::ACT_MERGE,  64'd0, 14'd5, 6'd3);
        send(csru_pkg::ACT_INSERT, 64'h0000_0000_0000_0001, 14'd0, 6'd0);
        send(csru_pkg::ACT_INSERT, '1, 14'd0, 6'd0);
        send(csru_pkg::ACT_QUERY,  '1, 14'h3FFF, 6'h3F);
        send(csru_pkg::ACT_CLEAR,  64'd0, 14'd0, 6'd0);
        send(csru_pkg::ACT_INSERT, 64'h1234_5678_9ABC_DEF0, 14'd0, 6'd0);
        send(csru_pkg::ACT_QUERY,  64'd0, 14'd0, 6'd0);
        s_valid = 1'b0;

        for (int p = 0; p < 8; p++) begin
            calm = (p == 7);
            drain();
            // Write precision last so the earlier clears sweep the old size.
            write_reg(csru_pkg::REG_START, phase_cfg[p][3]);
            write_reg(csru_pkg::REG_FINE, phase_cfg[p][1]);
            write_reg(csru_pkg::REG_LIMIT, phase_cfg[p][2]);
            write_reg(csru_pkg::REG_PRECISION, phase_cfg[p][0]);
            recent_hash.delete();
            for (int n = 0; n < 92; n++) begin
                random_beat();
                if (p == 2 && n == 40) begin
                    s_valid = 1'b0;
                    drain();
                end
            end
            s_valid = 1'b0;
        end

        drain();
        if (sketch.errors == 0 && sketch.status_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
